[rtl/nor_flash_array_model_macros.svh]
// Assertion macros used by the top level of the NOR flash array model.
`ifndef NOR_FLASH_ARRAY_MODEL_MACROS_SVH
`define NOR_FLASH_ARRAY_MODEL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define NFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfa: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define NFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfa: next-cycle check failed");

`endif

[rtl/nfa_pkg.sv]
// Shared constants, command codes and control/status types of the flash array model.
`timescale 1ns / 1ps
`default_nettype none

package nfa_pkg;

    // Array geometry
    localparam int unsigned SECTOR_COUNT = 16;
    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned ARRAY_BYTES  = SECTOR_COUNT * SECTOR_BYTES;

    // Memory index width and width of the unbounded flat address
    localparam int unsigned MEM_AW = $clog2(ARRAY_BYTES);
    localparam int unsigned FULL_W = 8 + $clog2(SECTOR_BYTES + 1) + 1;

    localparam logic [7:0] ERASED = 8'hFF;

    typedef enum logic [1:0] {
        CMD_READ         = 2'd0,
        CMD_PROGRAM      = 2'd1,
        CMD_ERASE_SECTOR = 2'd2,
        CMD_ERASE_ALL    = 2'd3
    } nfa_cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;       // latch the input beat, start the array read
        logic sweep_sector;  // load sweep range with the captured sector
        logic sweep_all;     // load sweep range with the whole array
        logic sweep_step;    // write 0xFF at the sweep pointer and advance
        logic prog_write;    // write back the ANDed byte
        logic out_load;      // load the result registers
    } nfa_ctl_t;

    // Datapath to controller
    typedef struct packed {
        nfa_cmd_t cmd;
        logic     ok;
        logic     sweep_last;
    } nfa_stat_t;

endpackage

`default_nettype wire

[rtl/nfa_datapath.sv]
// Datapath of the flash array model: byte memory, command latch, erase sweep and result registers.
`timescale 1ns / 1ps
`default_nettype none

module nfa_datapath
    import nfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  sector,
    input  wire logic [15:0] offset,
    input  wire logic [7:0]  write_data,
    input  wire logic        last_byte,
    input  wire nfa_ctl_t    ctl,
    output nfa_stat_t        stat,
    output logic [7:0]       read_data,
    output logic             in_range,
    output logic             last
);

    localparam logic [MEM_AW-1:0] SECT_LAST  = MEM_AW'(SECTOR_BYTES - 1);
    localparam logic [MEM_AW-1:0] ARRAY_LAST = MEM_AW'(ARRAY_BYTES - 1);

    logic [7:0] mem [ARRAY_BYTES];

    nfa_cmd_t          cmd_reg;
    logic              ok_reg;
    logic [MEM_AW-1:0] addr_reg;
    logic [MEM_AW-1:0] base_reg;
    logic [7:0]        wdata_reg;
    logic              last_in_reg;
    logic [7:0]        rd_data_reg;
    logic [MEM_AW-1:0] swp_addr_reg;
    logic [MEM_AW-1:0] swp_end_reg;
    logic [7:0]        read_data_reg;
    logic              in_range_reg;
    logic              last_reg;

    nfa_cmd_t          cmd_in;
    logic [FULL_W-1:0] base_full;
    logic [FULL_W-1:0] addr_full;
    logic              ok_in;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        prog_byte;
    logic [7:0]        result_byte;

    // Flat address and range check of the incoming beat
    always_comb
    begin
        cmd_in    = nfa_cmd_t'(command);
        base_full = FULL_W'(sector) * FULL_W'(SECTOR_BYTES);
        addr_full = base_full + FULL_W'(offset);
        unique case (cmd_in)
            CMD_READ, CMD_PROGRAM: ok_in = (addr_full < FULL_W'(ARRAY_BYTES));
            CMD_ERASE_SECTOR:      ok_in = ({1'b0, sector} < 9'(SECTOR_COUNT));
            CMD_ERASE_ALL:         ok_in = 1'b1;
            default:               ok_in = 1'b0;
        endcase
    end

    // Command latch
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg     <= cmd_in;
            ok_reg      <= ok_in;
            addr_reg    <= addr_full[MEM_AW-1:0];
            base_reg    <= base_full[MEM_AW-1:0];
            wdata_reg   <= write_data;
            last_in_reg <= last_byte;
        end
    end

    // Memory ports: one registered read, one write
    assign rd_addr   = ctl.capture ? addr_full[MEM_AW-1:0] : addr_reg;
    assign prog_byte = rd_data_reg & wdata_reg;
    assign wr_en     = ctl.sweep_step | ctl.prog_write;
    assign wr_addr   = ctl.sweep_step ? swp_addr_reg : addr_reg;
    assign wr_data   = ctl.sweep_step ? ERASED : prog_byte;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Erase sweep range; reset value covers the power-up clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swp_addr_reg <= '0;
            swp_end_reg  <= ARRAY_LAST;
        end
        else if (ctl.sweep_all)
        begin
            swp_addr_reg <= '0;
            swp_end_reg  <= ARRAY_LAST;
        end
        else if (ctl.sweep_sector)
        begin
            swp_addr_reg <= base_reg;
            swp_end_reg  <= base_reg + SECT_LAST;
        end
        else if (ctl.sweep_step)
        begin
            swp_addr_reg <= swp_addr_reg + 1'b1;
        end
    end

    // Result byte
    always_comb
    begin
        if (!ok_reg)
        begin
            result_byte = 8'h00;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_READ:    result_byte = rd_data_reg;
                CMD_PROGRAM: result_byte = prog_byte;
                default:     result_byte = ERASED;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            read_data_reg <= result_byte;
            in_range_reg  <= ok_reg;
            last_reg      <= last_in_reg;
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.ok         = ok_reg;
    assign stat.sweep_last = (swp_addr_reg == swp_end_reg);

    assign read_data = read_data_reg;
    assign in_range  = in_range_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[rtl/nfa_controller.sv]
// Controller of the flash array model: command sequencing, erase sweeps and handshakes.
`timescale 1ns / 1ps
`default_nettype none

module nfa_controller
    import nfa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire nfa_stat_t stat,
    output nfa_ctl_t       ctl
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ERASE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   is_erase;

    assign out_free = !out_valid_reg || out_ready;
    assign is_erase = (stat.cmd == CMD_ERASE_SECTOR) || (stat.cmd == CMD_ERASE_ALL);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (is_erase && stat.ok)
                begin
                    ctl.sweep_sector = (stat.cmd == CMD_ERASE_SECTOR);
                    ctl.sweep_all    = (stat.cmd == CMD_ERASE_ALL);
                    state_next       = S_ERASE;
                end
                else if (out_free)
                begin
                    ctl.prog_write = (stat.cmd == CMD_PROGRAM) && stat.ok;
                    ctl.out_load   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ERASE:
            begin
                ctl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat valid
    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/nor_flash_array_model.sv]
// Top level of the sectored NOR flash byte array model.
//
//  channel  | handshake            | beat fields
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_ready  | command, sector, offset, write_data, last_byte
//  output   | out_valid / out_ready| read_data, in_range, last
//
// Read and program: accept, then a registered array read and, for a program,
// the AND write-back through the single write port; the next beat is taken
// only after that. Sector erase and erase all sweep the sector or the whole
// array; the sweep writes one byte per cycle. After reset a clearing pass sets
// the array to 0xFF; in_ready stays low meanwhile. A stalled result holds the
// next beat in S_EXEC, or an erase in S_DONE, until the output frees.
`timescale 1ns / 1ps
`default_nettype none
`include "nor_flash_array_model_macros.svh"

module nor_flash_array_model
    import nfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  sector,
    input  wire logic [15:0] offset,
    input  wire logic [7:0]  write_data,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       read_data,
    output logic             in_range,
    output logic             last
);

    nfa_ctl_t  ctl;
    nfa_stat_t stat;

    nfa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    nfa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .sector     (sector),
        .offset     (offset),
        .write_data (write_data),
        .last_byte  (last_byte),
        .ctl        (ctl),
        .stat       (stat),
        .read_data  (read_data),
        .in_range   (in_range),
        .last       (last)
    );

    // One command in flight at a time
    `NFA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // The write port is never claimed twice
    `NFA_ASSERT_NOW(a_single_writer, ctl.prog_write, !ctl.sweep_step)
    // A result is loaded only while a command is in flight
    `NFA_ASSERT_NOW(a_load_busy, ctl.out_load, !in_ready)
    // Loading a result ends the command
    `NFA_ASSERT_NEXT(a_load_ends, ctl.out_load, in_ready && out_valid)

endmodule

`default_nettype wire

[verif/tb_nor_flash_array_model.sv]
// Testbench for the sectored NOR flash byte array: directed table, random transfers, scoreboard.
`timescale 1ns / 1ps

module tb_nor_flash_array_model;
    import nfa_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned RANDOM_BEATS  = 830;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned ERASE_ALL_CAP = 3;
    localparam int          DIRECTED_ROWS = 25;

    // One expected response beat
    typedef struct {
        logic [7:0] data;
        logic       ok;
        logic       lastb;
    } flash_result_t;

    // One row of the directed table; typed rows carry their own expected data
    typedef struct {
        nfa_cmd_t   cmd;
        logic [7:0] sec;
        logic [15:0] off;
        logic [7:0] wdata;
        logic       lastb;
        bit         typed;
        logic [7:0] exp_data;
        logic       exp_ok;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [7:0]  sector = '0;
    logic [15:0] offset = '0;
    logic [7:0]  write_data = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic        in_range;
    logic        last;

    // Shadow copy of the array and the responses still owed by the block
    logic [7:0]    flash_img [0:ARRAY_BYTES-1];
    flash_result_t pending_results [$];
    cmd_row_t      directed [DIRECTED_ROWS];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned random_sent = 0;
    int unsigned erase_all_sent = 0;
    int unsigned stall_left = 0;
    bit          steady_flow = 1'b0;

    nor_flash_array_model uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .sector     (sector),
        .offset     (offset),
        .write_data (write_data),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .in_range   (in_range),
        .last       (last)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Apply one command to the shadow array and return the response it gives
    task automatic apply_flash_command(
        input  nfa_cmd_t      cmd,
        input  logic [7:0]    sec,
        input  logic [15:0]   off,
        input  logic [7:0]    wdata,
        input  logic          lastb,
        output flash_result_t res
    );
        logic [31:0] flat;
        logic [31:0] base;
        flat = 32'(sec) * SECTOR_BYTES + 32'(off);
        res.data  = 8'h00;
        res.ok    = 1'b0;
        res.lastb = lastb;
        case (cmd)
            CMD_READ:
            begin
                if (flat < ARRAY_BYTES)
                begin
                    res.data = flash_img[flat];
                    res.ok   = 1'b1;
                end
            end
            CMD_PROGRAM:
            begin
                if (flat < ARRAY_BYTES)
                begin
                    flash_img[flat] = flash_img[flat] & wdata;
                    res.data = flash_img[flat];
                    res.ok   = 1'b1;
                end
            end
            CMD_ERASE_SECTOR:
            begin
                if (sec < SECTOR_COUNT)
                begin
                    base = 32'(sec) * SECTOR_BYTES;
                    for (int unsigned a = 0; a < SECTOR_BYTES; a++)
                        flash_img[base + a] = ERASED;
                    res.data = ERASED;
                    res.ok   = 1'b1;
                end
            end
            default:
            begin
                for (int unsigned a = 0; a < ARRAY_BYTES; a++)
                    flash_img[a] = ERASED;
                res.data = ERASED;
                res.ok   = 1'b1;
            end
        endcase
    endtask

    // Idle length before a beat: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one command beat, wait for acceptance, then log its response
    task automatic issue_command(
        input nfa_cmd_t    cmd,
        input logic [7:0]  sec,
        input logic [15:0] off,
        input logic [7:0]  wdata,
        input logic        lastb,
        input bit          typed,
        input logic [7:0]  exp_data,
        input logic        exp_ok
    );
        int unsigned   gap;
        flash_result_t res;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        sector     <= sec;
        offset     <= off;
        write_data <= wdata;
        last_byte  <= lastb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_flash_command(cmd, sec, off, wdata, lastb, res);
        if (typed)
        begin
            res.data = exp_data;
            res.ok   = exp_ok;
        end
        pending_results.push_back(res);
    endtask

    // Hold the input side until every owed response has come back
    task automatic drain_responses();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // A read or program transfer over consecutive bytes, last_byte on the final one
    task automatic send_transfer();
        nfa_cmd_t    cmd;
        logic [7:0]  sec;
        logic [15:0] base;
        int unsigned len;
        int unsigned pick;
        cmd  = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_PROGRAM;
        sec  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, SECTOR_COUNT - 1));
        pick = $urandom_range(0, 9);
        if (pick < 6)
            base = 16'($urandom_range(0, 7));
        else if (pick < 9)
            base = 16'($urandom_range(SECTOR_BYTES - 6, SECTOR_BYTES - 1));
        else
            base = 16'($urandom());
        len = $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++)
        begin
            issue_command(cmd, sec, base + 16'(i), 8'($urandom()), i == len - 1,
                          1'b0, 8'h00, 1'b0);
            random_sent++;
        end
    endtask

    // One random beat of any kind; erases kept rare since they sweep a whole sector or the array
    task automatic send_random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            send_transfer();
        else
        begin
            if (r < 94)
                issue_command(($urandom_range(0, 1) == 0) ? CMD_READ : CMD_PROGRAM,
                              8'($urandom()), 16'($urandom()), 8'($urandom()),
                              1'($urandom()), 1'b0, 8'h00, 1'b0);
            else if (r < 98 || erase_all_sent >= ERASE_ALL_CAP)
                issue_command(CMD_ERASE_SECTOR, 8'($urandom_range(0, 2 * SECTOR_COUNT - 1)),
                              16'($urandom()), 8'($urandom()), 1'($urandom()),
                              1'b0, 8'h00, 1'b0);
            else
            begin
                issue_command(CMD_ERASE_ALL, 8'($urandom()), 16'($urandom()),
                              8'($urandom()), 1'($urandom()), 1'b0, 8'h00, 1'b0);
                erase_all_sent++;
            end
            random_sent++;
        end
    endtask

    // Response side: random stalls, none while the flow is steady
    always @(posedge clk)
    begin : sink_pacing
        int unsigned r;
        r = $urandom_range(0, 99);
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (steady_flow || r < 70)
            out_ready <= 1'b1;
        else
        begin
            out_ready  <= 1'b0;
            stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        end
    end

    // Compare each response beat with the oldest owed one
    always @(posedge clk)
    begin : check_results
        flash_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("response with none owed: read_data=%h in_range=%b",
                                     read_data, in_range));
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.data)
                    flag_error($sformatf("read_data got %h want %h", read_data, want.data));
                if (in_range !== want.ok)
                    flag_error($sformatf("in_range got %b want %b", in_range, want.ok));
                if (last !== want.lastb)
                    flag_error($sformatf("last got %b want %b", last, want.lastb));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        // Boundary addresses, sticky program bits, every erase flavor
        directed = '{
            '{CMD_READ,         8'd0,   16'd0,     8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd15,  16'd4095,  8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd0,   16'd65535, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd16,  16'd0,     8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
            '{CMD_READ,         8'd255, 16'd65535, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},
            '{CMD_PROGRAM,      8'd0,   16'd0,     8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
            '{CMD_PROGRAM,      8'd0,   16'd0,     8'h3C, 1'b1, 1'b0, 8'h00, 1'b0},
            '{CMD_READ,         8'd0,   16'd0,     8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
            '{CMD_PROGRAM,      8'd15,  16'd4095,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
            '{CMD_PROGRAM,      8'd1,   16'd4096,  8'h0F, 1'b1, 1'b0, 8'h00, 1'b0},
            '{CMD_READ,         8'd2,   16'd0,     8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
            '{CMD_PROGRAM,      8'd16,  16'd0,     8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
            '{CMD_PROGRAM,      8'd1,   16'd61440, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
            '{CMD_READ,         8'd15,  16'd4095,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
            '{CMD_ERASE_SECTOR, 8'd15,  16'd65535, 8'h12, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd15,  16'd4095,  8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd0,   16'd0,     8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
            '{CMD_ERASE_SECTOR, 8'd16,  16'd0,     8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
            '{CMD_ERASE_SECTOR, 8'd255, 16'd65535, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0},
            '{CMD_ERASE_SECTOR, 8'd0,   16'd0,     8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd0,   16'd0,     8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_PROGRAM,      8'd7,   16'd100,   8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
            '{CMD_ERASE_ALL,    8'd200, 16'd1234,  8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd7,   16'd100,   8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
            '{CMD_READ,         8'd2,   16'd0,     8'h00, 1'b1, 1'b1, 8'hFF, 1'b1}
        };
        for (int unsigned a = 0; a < ARRAY_BYTES; a++)
            flash_img[a] = ERASED;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part; in_ready stays low through the clearing pass
        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_command(directed[i].cmd, directed[i].sec, directed[i].off,
                          directed[i].wdata, directed[i].lastb, directed[i].typed,
                          directed[i].exp_data, directed[i].exp_ok);
        drain_responses();

        // Random part in phases; two phases run with no idling on either side
        for (int unsigned p = 0; p < PHASE_COUNT; p++)
        begin
            steady_flow = (p == 2 || p == 5);
            while (random_sent < (p + 1) * RANDOM_BEATS / PHASE_COUNT)
                send_random_item();
            drain_responses();
        end
        steady_flow = 1'b0;

        // Let any stray response show up
        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d responses never arrived", pending_results.size()));
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
